/* rtl/core/tal_pkg.sv */
// Shared types, constants and the control program for the ancestor-lifting core.
// Depends on nothing; tal_seq, tal_dp and the top level in rtl/core import it.
package tal_pkg;

  localparam int NODE_FW    = 10;
  localparam int TIME_W     = 12;
  localparam int OP_W       = 2;
  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
  localparam logic [OP_W-1:0] OP_ENTER   = 2'd1;
  localparam logic [OP_W-1:0] OP_LEAVE   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

  // Input node fields kept side by side in the datapath.
  localparam int F_A    = 0;
  localparam int F_B    = 1;
  localparam int F_P    = 2;
  localparam int NFIELD = 3;

  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE  = 5'd0;
  localparam step_t S_RED1  = 5'd1;
  localparam step_t S_RED2  = 5'd2;
  localparam step_t S_RST   = 5'd3;
  localparam step_t S_LEAVE = 5'd4;
  localparam step_t S_ENT0  = 5'd5;
  localparam step_t S_ENT1  = 5'd6;
  localparam step_t S_ENT2  = 5'd7;
  localparam step_t S_Q0    = 5'd8;
  localparam step_t S_Q1    = 5'd9;
  localparam step_t S_Q2    = 5'd10;
  localparam step_t S_Q3    = 5'd11;
  localparam step_t S_Q4    = 5'd12;
  localparam step_t S_L0    = 5'd13;
  localparam step_t S_L1    = 5'd14;
  localparam step_t S_L2    = 5'd15;
  localparam step_t S_QE0   = 5'd16;
  localparam step_t S_QE1   = 5'd17;
  localparam step_t S_OUT   = 5'd18;

  typedef enum logic [1:0] {TA_A = 2'd0, TA_B = 2'd1, TA_TBL = 2'd2} tm_sel_e;
  typedef enum logic {TN_A = 1'b0, TN_U = 1'b1} tn_sel_e;
  typedef enum logic [1:0] {TL_ZERO = 2'd0, TL_LVL = 2'd1, TL_LVLM1 = 2'd2} tl_sel_e;
  typedef enum logic {TW_P = 1'b0, TW_RD = 1'b1} tw_sel_e;
  typedef enum logic [2:0] {
    U_HOLD = 3'd0, U_P = 3'd1, U_RD = 3'd2, U_A = 3'd3, U_W_IF = 3'd4
  } u_op_e;
  typedef enum logic [2:0] {
    LV_HOLD = 3'd0, LV_ONE = 3'd1, LV_TOP = 3'd2, LV_INC = 3'd3, LV_DEC = 3'd4
  } lv_op_e;
  typedef enum logic [1:0] {TM_HOLD = 2'd0, TM_ONE = 2'd1, TM_INC = 2'd2} tm_op_e;
  typedef enum logic [1:0] {R_HOLD = 2'd0, R_A = 2'd1, R_B = 2'd2, R_RD = 2'd3} res_op_e;
  typedef enum logic [3:0] {
    J_NEXT    = 4'd0,
    J_GOTO    = 4'd1,
    J_WAIT    = 4'd2,
    J_OP      = 4'd3,
    J_ANC_AB  = 4'd4,
    J_ANC_BA  = 4'd5,
    J_LVL_END = 4'd6,
    J_LVL_NZ  = 4'd7,
    J_OUT     = 4'd8,
    J_FIN     = 4'd9
  } jmp_e;

  typedef struct packed {
    tm_sel_e tm_sel;
    logic    en_wr;
    logic    ex_wr;
    tn_sel_e tn_sel;
    tl_sel_e tl_sel;
    logic    tb_wr;
    tw_sel_e tw_sel;
    logic    ld_q;
    logic    ld_red;
    logic    ld_ta;
    logic    ld_tb;
    logic    ld_w;
    u_op_e   u_op;
    lv_op_e  lv_op;
    tm_op_e  tm_op;
    res_op_e res_op;
    logic    out_ld;
    jmp_e    jmp;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            anc_ab;
    logic            anc_ba;
    logic            lvl_end;
    logic            lvl_nz;
    logic            out_busy;
  } stat_t;

  function automatic step_t op_entry(input logic [OP_W-1:0] op);
    step_t s;
    case (op)
      OP_RESTART: s = S_RST;
      OP_ENTER:   s = S_ENT0;
      OP_LEAVE:   s = S_LEAVE;
      OP_QUERY:   s = S_Q0;
      default:    s = S_IDLE;
    endcase
    return s;
  endfunction

  // The control program: one word per step.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '0;
    case (step)
      S_IDLE:  c.jmp = J_WAIT;
      S_RED1:  c.ld_q = 1'b1;
      S_RED2: begin
        c.ld_red = 1'b1;
        c.jmp    = J_OP;
      end
      S_RST: begin
        c.tm_op = TM_ONE;
        c.jmp   = J_FIN;
      end
      S_LEAVE: begin
        c.ex_wr = 1'b1;
        c.tm_op = TM_INC;
        c.jmp   = J_FIN;
      end
      S_ENT0: begin
        c.en_wr  = 1'b1;
        c.tm_op  = TM_INC;
        c.tb_wr  = 1'b1;
        c.tn_sel = TN_A;
        c.tl_sel = TL_ZERO;
        c.tw_sel = TW_P;
        c.u_op   = U_P;
        c.lv_op  = LV_ONE;
      end
      S_ENT1: begin
        c.tn_sel = TN_U;
        c.tl_sel = TL_LVLM1;
        c.jmp    = J_LVL_END;
        c.target = S_IDLE;
      end
      S_ENT2: begin
        c.tb_wr  = 1'b1;
        c.tn_sel = TN_A;
        c.tl_sel = TL_LVL;
        c.tw_sel = TW_RD;
        c.u_op   = U_RD;
        c.lv_op  = LV_INC;
        c.jmp    = J_GOTO;
        c.target = S_ENT1;
      end
      S_Q0:    c.tm_sel = TA_A;
      S_Q1: begin
        c.tm_sel = TA_B;
        c.ld_ta  = 1'b1;
      end
      S_Q2:    c.ld_tb = 1'b1;
      S_Q3: begin
        c.res_op = R_A;
        c.jmp    = J_ANC_AB;
        c.target = S_OUT;
      end
      S_Q4: begin
        c.res_op = R_B;
        c.u_op   = U_A;
        c.lv_op  = LV_TOP;
        c.jmp    = J_ANC_BA;
        c.target = S_OUT;
      end
      S_L0: begin
        c.tn_sel = TN_U;
        c.tl_sel = TL_LVL;
      end
      S_L1: begin
        c.tm_sel = TA_TBL;
        c.ld_w   = 1'b1;
      end
      S_L2: begin
        c.u_op   = U_W_IF;
        c.lv_op  = LV_DEC;
        c.jmp    = J_LVL_NZ;
        c.target = S_L0;
      end
      S_QE0: begin
        c.tn_sel = TN_U;
        c.tl_sel = TL_ZERO;
      end
      S_QE1:   c.res_op = R_RD;
      S_OUT: begin
        c.out_ld = 1'b1;
        c.jmp    = J_OUT;
      end
      default: c.jmp = J_FIN;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/tree_ancestor_lifting_table_core.sv */
// Lowest-common-ancestor core: entry/exit timestamps and a binary-lifting table.
// Top level; depends on tal_pkg, tal_seq, tal_dp and tal_ram.
//
// Usage: a feeder walking the tree sends one beat per event on the input channel
// (operation, node_a, node_b, parent_node). Restart sets the timer to 1, enter
// stamps a node and fills its lifting row, leave stamps its exit time, and a
// query returns one beat on the output channel with the common ancestor.
// Both channels are valid/stall; a beat moves when valid is high and stall low.
// The core works on one item at a time and stalls its input while busy.
// Steps per item, after the reduction steps and until back to idle:
//   restart, leave: the timer step (leave also writes the exit stamp)
//   enter: the stamp and level-0 step, then each lifting level is one table read and one write
//   query: ends after the stamp compare when node_a is above node_b or node_b is above node_a, else
//          climbs each level (a table read, a timestamp read and a compare) before the result.
// The three stores are single-port-read RAMs with registered output, which sets
// the per-level step count. Reset clears the sequencer and output valid and sets
// the timer to 1; the RAMs are not cleared and need no clearing pass. When the
// receiver stalls, the result is held and the core keeps working; a further
// result waits in its last step until the output register is free.
module tree_ancestor_lifting_table_core
  import tal_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [NODE_FW-1:0] node_a_i,
  input  logic [NODE_FW-1:0] node_b_i,
  input  logic [NODE_FW-1:0] parent_node_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [NODE_FW-1:0] common_ancestor_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  idle;
  logic  accept;

  assign in_stall_o = !idle;
  assign accept     = in_valid_i && idle;

  tal_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (stat),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  tal_dp #(.NODES(NODES), .LEVELS(LEVELS)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .operation_i       (operation_i),
    .node_a_i          (node_a_i),
    .node_b_i          (node_b_i),
    .parent_node_i     (parent_node_i),
    .c_i               (ctrl),
    .st_o              (stat),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .common_ancestor_o (common_ancestor_o)
  );

endmodule

/* rtl/core/tal_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the timestamp stores and the lifting table.
module tal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/tal_seq.sv */
// Step counter and jump logic that walks the control program in tal_pkg.
// Depends on tal_pkg; feeds control words to tal_dp and reads back its status.
module tal_seq
  import tal_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t st_i,
  output ctrl_t ctrl_o,
  output logic  idle_o
);

  step_t step_q, step_d;
  ctrl_t c;

  assign c      = ucode(step_q);
  assign ctrl_o = c;
  assign idle_o = (step_q == S_IDLE);

  always_comb begin
    case (c.jmp)
      J_NEXT:    step_d = step_q + step_t'(1);
      J_GOTO:    step_d = c.target;
      J_WAIT:    step_d = in_valid_i ? step_q + step_t'(1) : step_q;
      J_OP:      step_d = op_entry(st_i.op);
      J_ANC_AB:  step_d = st_i.anc_ab ? c.target : step_q + step_t'(1);
      J_ANC_BA:  step_d = st_i.anc_ba ? c.target : step_q + step_t'(1);
      J_LVL_END: step_d = st_i.lvl_end ? c.target : step_q + step_t'(1);
      J_LVL_NZ:  step_d = st_i.lvl_nz ? c.target : step_q + step_t'(1);
      // The result step waits here until the output register can take the beat.
      J_OUT:     step_d = st_i.out_busy ? step_q : S_IDLE;
      J_FIN:     step_d = S_IDLE;
      default:   step_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_IDLE) && !in_valid_i |=> (step_q == S_IDLE))
    else $error("sequencer left idle without an input beat");

  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_OUT) && st_i.out_busy |=> (step_q == S_OUT))
    else $error("result step left while the output register was full");

endmodule

/* rtl/core/tal_dp.sv */
// Datapath: input capture, node reduction, timer, the three RAMs and the output register.
// Depends on tal_pkg and tal_ram; steered by the control words from tal_seq.
module tal_dp
  import tal_pkg::*;
#(
  parameter int NODES  = NODES_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [NODE_FW-1:0]  node_a_i,
  input  logic [NODE_FW-1:0]  node_b_i,
  input  logic [NODE_FW-1:0]  parent_node_i,
  input  ctrl_t               c_i,
  output stat_t               st_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [NODE_FW-1:0]  common_ancestor_o
);

  localparam int NW        = $clog2(NODES);
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LCW       = $clog2(LEVELS + 1);
  localparam int TBL_DEPTH = NODES * (2 ** LW);

  logic [OP_W-1:0]    op_q;
  logic [NODE_FW-1:0] raw_q [NFIELD];
  logic [NODE_FW-1:0] mid_q [NFIELD];
  logic [NODE_FW-1:0] mid_d [NFIELD];
  logic [NW-1:0]      red_q [NFIELD];
  logic [NW-1:0]      red_d [NFIELD];
  logic [TIME_W-1:0]  timer_q, timer_d;
  logic [NW-1:0]      u_q, u_d;
  logic [NW-1:0]      w_q;
  logic [LCW-1:0]     lvl_q, lvl_d, lvl_m1;
  logic [TIME_W-1:0]  ta_en_q, ta_ex_q, tb_en_q, tb_ex_q;
  logic [NW-1:0]      res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic [NODE_FW-1:0] out_ca_q;
  logic               out_busy, out_load;

  logic [NW-1:0]      tm_addr;
  logic [TIME_W-1:0]  en_rd, ex_rd;
  logic [NW-1:0]      tbl_node;
  logic [LW-1:0]      tbl_lvl;
  logic [NW+LW-1:0]   tbl_addr;
  logic [NW-1:0]      tbl_wdata, tbl_rd;
  logic               anc_ab, anc_ba, anc_up;

  function automatic logic is_anc(input logic [TIME_W-1:0] xe, input logic [TIME_W-1:0] xx,
                                  input logic [TIME_W-1:0] ye, input logic [TIME_W-1:0] yx);
    return (xe <= ye) && (xx >= yx);
  endfunction

  // Node numbers at or above NODES wrap modulo NODES; below 1024 nodes this takes
  // a reciprocal multiply in one step and a multiply-back and subtract in the next.
  for (genvar f = 0; f < NFIELD; f++) begin : g_red
    if (NODES >= 2 ** NODE_FW) begin : g_ident
      assign mid_d[f] = raw_q[f];
      assign red_d[f] = NW'(mid_q[f]);
    end else begin : g_recip
      localparam int RS = 2 * NODE_FW;
      localparam int PW = 3 * NODE_FW;
      localparam int RECIP = ((2 ** RS) + NODES - 1) / NODES;
      logic [PW-1:0]        prod;
      logic [2*NODE_FW-1:0] qn;
      logic [NODE_FW-1:0]   rem, corr;
      assign prod     = PW'(raw_q[f]) * PW'(RECIP);
      assign mid_d[f] = prod[PW-1:RS];
      assign qn       = (2*NODE_FW)'(mid_q[f]) * (2*NODE_FW)'(NODES);
      assign rem      = raw_q[f] - qn[NODE_FW-1:0];
      assign corr     = (rem >= NODE_FW'(NODES)) ? rem - NODE_FW'(NODES) : rem;
      assign red_d[f] = NW'(corr);
    end
  end

  assign lvl_m1 = lvl_q - LCW'(1);

  always_comb begin
    case (c_i.tm_sel)
      TA_A:    tm_addr = red_q[F_A];
      TA_B:    tm_addr = red_q[F_B];
      TA_TBL:  tm_addr = tbl_rd;
      default: tm_addr = red_q[F_A];
    endcase
    case (c_i.tl_sel)
      TL_ZERO:  tbl_lvl = '0;
      TL_LVL:   tbl_lvl = lvl_q[LW-1:0];
      TL_LVLM1: tbl_lvl = lvl_m1[LW-1:0];
      default:  tbl_lvl = '0;
    endcase
  end

  assign tbl_node  = (c_i.tn_sel == TN_U) ? u_q : red_q[F_A];
  assign tbl_addr  = {tbl_node, tbl_lvl};
  assign tbl_wdata = (c_i.tw_sel == TW_RD) ? tbl_rd : red_q[F_P];

  tal_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (c_i.en_wr),
    .waddr_i (red_q[F_A]),
    .wdata_i (timer_q),
    .raddr_i (tm_addr),
    .rdata_o (en_rd)
  );

  tal_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_exit_ram (
    .clk_i   (clk_i),
    .we_i    (c_i.ex_wr),
    .waddr_i (red_q[F_A]),
    .wdata_i (timer_q),
    .raddr_i (tm_addr),
    .rdata_o (ex_rd)
  );

  tal_ram #(.WIDTH(NW), .DEPTH(TBL_DEPTH)) u_lift_ram (
    .clk_i   (clk_i),
    .we_i    (c_i.tb_wr),
    .waddr_i (tbl_addr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_addr),
    .rdata_o (tbl_rd)
  );

  assign anc_ab = is_anc(ta_en_q, ta_ex_q, tb_en_q, tb_ex_q);
  assign anc_ba = is_anc(tb_en_q, tb_ex_q, ta_en_q, ta_ex_q);
  assign anc_up = is_anc(en_rd, ex_rd, tb_en_q, tb_ex_q);

  always_comb begin
    case (c_i.tm_op)
      TM_ONE:  timer_d = TIME_W'(1);
      TM_INC:  timer_d = timer_q + TIME_W'(1);
      default: timer_d = timer_q;
    endcase
    case (c_i.u_op)
      U_P:     u_d = red_q[F_P];
      U_RD:    u_d = tbl_rd;
      U_A:     u_d = red_q[F_A];
      // Climb only while the ancestor found is still not above the second node.
      U_W_IF:  u_d = anc_up ? u_q : w_q;
      default: u_d = u_q;
    endcase
    case (c_i.lv_op)
      LV_ONE:  lvl_d = LCW'(1);
      LV_TOP:  lvl_d = LCW'(LEVELS - 1);
      LV_INC:  lvl_d = lvl_q + LCW'(1);
      LV_DEC:  lvl_d = lvl_m1;
      default: lvl_d = lvl_q;
    endcase
    case (c_i.res_op)
      R_A:     res_d = red_q[F_A];
      R_B:     res_d = red_q[F_B];
      R_RD:    res_d = tbl_rd;
      default: res_d = res_q;
    endcase
  end

  assign out_busy    = out_valid_q && out_stall_i;
  assign out_load    = c_i.out_ld && !out_busy;
  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q     <= TIME_W'(1);
      out_valid_q <= 1'b0;
      lvl_q       <= '0;
    end else begin
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
      lvl_q       <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q       <= operation_i;
      raw_q[F_A] <= node_a_i;
      raw_q[F_B] <= node_b_i;
      raw_q[F_P] <= parent_node_i;
    end
    if (c_i.ld_q) begin
      mid_q <= mid_d;
    end
    if (c_i.ld_red) begin
      red_q <= red_d;
    end
    if (c_i.ld_ta) begin
      ta_en_q <= en_rd;
      ta_ex_q <= ex_rd;
    end
    if (c_i.ld_tb) begin
      tb_en_q <= en_rd;
      tb_ex_q <= ex_rd;
    end
    if (c_i.ld_w) begin
      w_q <= tbl_rd;
    end
    if (out_load) begin
      out_ca_q <= NODE_FW'(res_q);
    end
    u_q   <= u_d;
    res_q <= res_d;
  end

  assign st_o.op       = op_q;
  assign st_o.anc_ab   = anc_ab;
  assign st_o.anc_ba   = anc_ba;
  assign st_o.lvl_end  = (lvl_q == LCW'(LEVELS));
  assign st_o.lvl_nz   = (lvl_q != '0);
  assign st_o.out_busy = out_busy;

  assign out_valid_o       = out_valid_q;
  assign common_ancestor_o = out_ca_q;

  a_lift_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_i.tb_wr |-> (c_i.tl_sel == TL_ZERO) || (lvl_q < LCW'(LEVELS)))
    else $error("lifting row written beyond its last level");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(c_i.out_ld))
    else $error("output beat raised outside the result step");

  a_stamp_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_i.en_wr || c_i.ex_wr) |-> (c_i.tm_op == TM_INC))
    else $error("timestamp written without advancing the timer");

endmodule

/* verif/tal_lca_checker.sv */
// Checker for the ancestor-lifting core: watches both channels, keeps its own
// timestamps and lifting rows, and compares every returned ancestor in order.
// Depends on tal_pkg for widths and operation codes.
module tal_lca_checker
  import tal_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [NODE_FW-1:0] node_a_i,
  input  logic [NODE_FW-1:0] node_b_i,
  input  logic [NODE_FW-1:0] parent_node_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [NODE_FW-1:0] common_ancestor_i,
  output int                 mismatches_o,
  output int                 awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES  = NODES_DEF;
  localparam int LEVELS = LEVELS_DEF;
  localparam int SHOWN  = 10;

  typedef logic [NODE_FW-1:0] node_t;
  typedef logic [TIME_W-1:0]  stamp_t;

  stamp_t event_clock;
  stamp_t entered_at [NODES];
  stamp_t left_at    [NODES];
  node_t  lift_row   [NODES][LEVELS];
  node_t  expected_lca[$];
  node_t  lca;

  function automatic int wrap_node(input node_t n);
    return int'(n) % NODES;
  endfunction

  function automatic int jump(input int n, input int lvl);
    return wrap_node(lift_row[n][lvl]);
  endfunction

  function automatic bit encloses(input int u, input int v);
    return entered_at[u] <= entered_at[v] && left_at[u] >= left_at[v];
  endfunction

  // Applies one input beat to the mirrored state; returns 1 with the ancestor
  // when the beat is a query.
  function automatic bit step_lca(input logic [OP_W-1:0] op, input node_t a_in,
                                  input node_t b_in, input node_t p_in,
                                  output node_t answer);
    int a;
    int b;
    int up;
    int mid;
    a = wrap_node(a_in);
    b = wrap_node(b_in);
    answer = '0;
    case (op)
      OP_RESTART: event_clock = stamp_t'(1);
      OP_ENTER: begin
        entered_at[a] = event_clock;
        event_clock++;
        lift_row[a][0] = node_t'(wrap_node(p_in));
        for (int lvl = 1; lvl < LEVELS; lvl++) begin
          mid = jump(a, lvl - 1);
          lift_row[a][lvl] = node_t'(jump(mid, lvl - 1));
        end
      end
      OP_LEAVE: begin
        left_at[a] = event_clock;
        event_clock++;
      end
      default: begin
        if (encloses(a, b)) begin
          answer = node_t'(a);
        end else if (encloses(b, a)) begin
          answer = node_t'(b);
        end else begin
          // Climb from a as far as possible while staying below the ancestor.
          for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            up = jump(a, lvl);
            if (!encloses(up, b)) a = up;
          end
          answer = node_t'(jump(a, 0));
        end
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_clock = stamp_t'(1);
      expected_lca.delete();
      awaiting_o = 0;
    end else begin
      // Results leave before this edge's input can add anything to wait for.
      if (out_valid_i && !out_stall_i) begin
        if (expected_lca.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= SHOWN)
            $display("%0t: result beat with nothing expected, got %0d", $realtime,
                     common_ancestor_i);
        end else begin
          lca = expected_lca.pop_front();
          if (common_ancestor_i !== lca) begin
            mismatches_o++;
            if (mismatches_o <= SHOWN)
              $display("%0t: common ancestor mismatch, expected %0d, got %0d",
                       $realtime, lca, common_ancestor_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i &&
          step_lca(operation_i, node_a_i, node_b_i, parent_node_i, lca))
        expected_lca.push_back(lca);
      awaiting_o = expected_lca.size();
    end
  end

endmodule

/* verif/tb.sv */
// Top of the ancestor-lifting core testbench: clock, reset, tree walks and
// queries on the input channel, a stalling receiver and the verdict.
// Depends on tal_pkg, the core and tal_lca_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tal_pkg::*;

  localparam int POOL_SIZE    = 48;
  localparam int RANDOM_BEATS = 660;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_PCT     = 14;

  typedef logic [NODE_FW-1:0] node_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            in_valid_i    = 1'b0;
  logic            in_stall_o;
  logic [OP_W-1:0] operation_i   = OP_RESTART;
  node_t           node_a_i      = '0;
  node_t           node_b_i      = '0;
  node_t           parent_node_i = '0;
  logic            out_valid_o;
  logic            out_stall_i   = 1'b0;
  node_t           common_ancestor_o;

  int    mismatches;
  int    awaiting;
  bit    calm         = 1'b0;
  bit    hold_request = 1'b0;
  int    beats_sent   = 0;
  node_t pool[$];
  node_t group[$];
  node_t tree_root;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  tree_ancestor_lifting_table_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .parent_node_i    (parent_node_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .common_ancestor_o(common_ancestor_o)
  );

  tal_lca_checker u_lca_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .parent_node_i    (parent_node_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .common_ancestor_i(common_ancestor_o),
    .mismatches_o     (mismatches),
    .awaiting_o       (awaiting)
  );

  function automatic node_t any_node();
    return node_t'($urandom);
  endfunction

  function automatic void scramble_group();
    int    j;
    node_t t;
    for (int i = group.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = group[i];
      group[i] = group[j];
      group[j] = t;
    end
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input node_t a, input node_t b,
                           input node_t p);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    node_a_i      <= a;
    node_b_i      <= b;
    parent_node_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
  endtask

  // Every pool node has stamps and a row after the first walk, and rows only
  // name pool nodes, so any enter with a pool parent or any pool query is safe.
  task automatic send_noise();
    logic [OP_W-1:0] op;
    op = OP_W'($urandom_range(3));
    case (op)
      OP_ENTER: send_beat(op, any_node(), any_node(), pool[$urandom_range(POOL_SIZE - 1)]);
      OP_QUERY: send_beat(op, pool[$urandom_range(POOL_SIZE - 1)],
                          pool[$urandom_range(POOL_SIZE - 1)], any_node());
      default:  send_beat(op, any_node(), any_node(), any_node());
    endcase
  endtask

  // Depth-first walk of a random tree over the group, root first.
  task automatic walk_tree(input bit noisy);
    node_t stack[$];
    int    next;
    scramble_group();
    tree_root = group[0];
    send_beat(OP_ENTER, tree_root, any_node(), tree_root);
    stack.push_back(tree_root);
    next = 1;
    while (stack.size() != 0) begin
      if (noisy && $urandom_range(99) < 8) send_noise();
      if (next < group.size() && (stack.size() == 1 || $urandom_range(99) < 55)) begin
        send_beat(OP_ENTER, group[next], any_node(), stack[$]);
        stack.push_back(group[next]);
        next++;
      end else begin
        send_beat(OP_LEAVE, stack[$], any_node(), any_node());
        void'(stack.pop_back());
      end
    end
  endtask

  task automatic ask_pairs(input int count);
    node_t a;
    node_t b;
    repeat (count) begin
      a = group[$urandom_range(group.size() - 1)];
      if ($urandom_range(9) == 0) b = a;
      else if ($urandom_range(3) == 0) b = pool[$urandom_range(POOL_SIZE - 1)];
      else b = group[$urandom_range(group.size() - 1)];
      send_beat(OP_QUERY, a, b, any_node());
    end
  endtask

  // Receiver: random stalls, or one long hold-off while the sender keeps going.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    bit    taken[1 << NODE_FW];
    node_t cand;
    int    start;
    int    round;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The pool holds both extreme node numbers, so every node bit toggles.
    pool.push_back('0);
    pool.push_back('1);
    taken[0] = 1'b1;
    taken[(1 << NODE_FW) - 1] = 1'b1;
    while (pool.size() < POOL_SIZE) begin
      cand = any_node();
      if (!taken[cand]) begin
        taken[cand] = 1'b1;
        pool.push_back(cand);
      end
    end
    group = pool;
    walk_tree(1'b0);

    send_beat(OP_QUERY, pool[1], pool[1], '0);
    send_beat(OP_QUERY, tree_root, pool[1], '1);
    send_beat(OP_QUERY, pool[1], tree_root, '0);
    send_beat(OP_QUERY, pool[0], pool[1], '1);
    send_beat(OP_QUERY, pool[1], pool[0], '0);
    send_beat(OP_QUERY, pool[0], pool[0], '1);
    send_beat(OP_RESTART, '1, '1, '1);
    send_beat(OP_LEAVE, '1, '0, '1);
    send_beat(OP_ENTER, '1, '1, '0);
    send_beat(OP_QUERY, '1, '0, '0);
    send_beat(OP_QUERY, '0, '1, '1);
    send_beat(OP_ENTER, '0, '0, '0);
    send_beat(OP_QUERY, '1, '0, '0);
    send_beat(OP_LEAVE, '0, '1, '0);
    send_beat(OP_QUERY, pool[2], '1, '0);
    send_beat(OP_RESTART, '0, '0, '0);
    send_beat(OP_QUERY, pool[3], pool[4], '1);
    wait_drained();

    start = beats_sent;
    round = 0;
    while (beats_sent - start < RANDOM_BEATS) begin
      calm = (round == 2);
      if (round % 4 == 0) send_beat(OP_RESTART, any_node(), any_node(), any_node());
      group = pool;
      scramble_group();
      cand = node_t'($urandom_range(2, 16));
      while (group.size() > cand) void'(group.pop_back());
      walk_tree(round % 3 == 1);
      if (round == 5) hold_request = 1'b1;
      ask_pairs($urandom_range(4, 14));
      if (round % 4 == 3) wait_drained();
      round++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
